[sv/sbl_pkg.sv]
// Package for the snapshot body layout checker.
// Holds the beat types, the layout constants, the parse phase codes and the status codes.
// No dependencies.
package sbl_pkg;

  localparam int unsigned ENTRY_BYTES     = 32;
  localparam int unsigned REC_FIXED_BYTES = 32 + 4 + 8 + 4;
  localparam int unsigned REC_LEN_AT      = 32 + 4 + 8;
  localparam int unsigned REC_TAIL_BYTES  = 4 + 1;
  localparam logic [63:0] COUNT_MAX       = 64'hFFFF_FFFF_FFFF_FFFF / 64'(ENTRY_BYTES);

  localparam logic [1:0] VER_2 = 2'd2;
  localparam logic [1:0] VER_3 = 2'd3;

  localparam logic CFG_FORMAT_VERSION = 1'b0;
  localparam logic CFG_RECORD_TOTAL   = 1'b1;

  localparam logic [3:0] PH_FIXED   = 4'd0;
  localparam logic [3:0] PH_TAIL    = 4'd1;
  localparam logic [3:0] PH_LEN1    = 4'd2;
  localparam logic [3:0] PH_SEC1    = 4'd3;
  localparam logic [3:0] PH_LEN2    = 4'd4;
  localparam logic [3:0] PH_SEC2    = 4'd5;
  localparam logic [3:0] PH_CNT     = 4'd6;
  localparam logic [3:0] PH_ENTRIES = 4'd7;
  localparam logic [3:0] PH_DONE1   = 4'd8;
  localparam logic [3:0] PH_DONE2   = 4'd9;
  localparam logic [3:0] PH_DONE3   = 4'd10;

  localparam logic [3:0] ST_RUNNING          = 4'd0;
  localparam logic [3:0] ST_ACCEPTED         = 4'd1;
  localparam logic [3:0] ST_TRUNC_RECORD     = 4'd2;
  localparam logic [3:0] ST_TRUNC_SCRIPT     = 4'd3;
  localparam logic [3:0] ST_V1_TRAILING      = 4'd4;
  localparam logic [3:0] ST_MISSING_LEN1     = 4'd5;
  localparam logic [3:0] ST_TRUNC_SEC1       = 4'd6;
  localparam logic [3:0] ST_EMPTY_V2_SECTION = 4'd7;
  localparam logic [3:0] ST_V2_TRAILING      = 4'd8;
  localparam logic [3:0] ST_MISSING_LEN2     = 4'd9;
  localparam logic [3:0] ST_TRUNC_SEC2       = 4'd10;
  localparam logic [3:0] ST_MISSING_COUNT    = 4'd11;
  localparam logic [3:0] ST_COUNT_OVERFLOW   = 4'd12;
  localparam logic [3:0] ST_TRUNC_ENTRIES    = 4'd13;
  localparam logic [3:0] ST_V3_TRAILING      = 4'd14;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_present;
    logic       body_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  check_status;
    logic [39:0] records_seen;
    logic        body_done;
  } out_item_t;

endpackage

[sv/snapshot_body_layout_checker.sv]
// Snapshot body layout checker, top level.
// Depends on sbl_pkg for the beat types, layout constants and status codes.
//
// Checks a snapshot body one byte per beat and returns one result beat per input beat. A new
// beat is taken every cycle while results drain; an accepted beat is held in the input register,
// then passes through the single-pass next-state logic (a 40-bit record compare, a 33-bit up/down
// field counter, a 64-bit down counter and the little-endian length assembly) into the result
// register. A held result stalls the input once the input register is also occupied. There is no
// clearing pass after reset. Write the configuration registers only while no body beat is in
// flight; record_total is compared on every beat, not only at record boundaries.
module snapshot_body_layout_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbl_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output sbl_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [39:0]       cfg_data
);

  logic [1:0]  format_version;
  logic [39:0] record_total;

  sbl_pkg::in_item_t in_q;
  logic              in_q_valid;
  logic              advance;

  logic [3:0]  parse_phase, parse_phase_next;
  logic [32:0] field_left, field_left_next;
  logic [39:0] records_done, records_done_next;
  logic [63:0] length_shift, length_shift_next;
  logic [63:0] section_left, section_left_next;
  logic [3:0]  first_error, first_error_next;

  logic [39:0] rd_inc;
  logic        ge_now, ge_inc, ge_end, ver23, tail_wrap;
  logic [1:0]  fixed_lane;
  logic [63:0] word_value;
  logic [3:0]  settled_phase;
  logic [3:0]  end_status;
  sbl_pkg::out_item_t result;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_version <= 2'd1;
      record_total   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbl_pkg::CFG_FORMAT_VERSION: format_version <= cfg_data[1:0];
        sbl_pkg::CFG_RECORD_TOTAL:   record_total   <= cfg_data;
        default:                     record_total   <= record_total;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  always_comb begin
    parse_phase_next  = parse_phase;
    field_left_next   = field_left;
    records_done_next = records_done;
    length_shift_next = length_shift;
    section_left_next = section_left;
    first_error_next  = first_error;
    tail_wrap         = 1'b0;
    word_value        = '0;
    rd_inc            = records_done + 40'd1;
    ge_now            = records_done >= record_total;
    ge_inc            = rd_inc >= record_total;
    ver23             = (format_version == sbl_pkg::VER_2) || (format_version == sbl_pkg::VER_3);
    fixed_lane        = 2'(field_left - 33'(sbl_pkg::REC_LEN_AT));

    if (in_q.byte_present && first_error == sbl_pkg::ST_RUNNING) begin
      if (parse_phase_next == sbl_pkg::PH_FIXED && field_left_next == '0 && ge_now) begin
        if (ver23) begin
          parse_phase_next  = sbl_pkg::PH_LEN1;
          field_left_next   = '0;
          length_shift_next = '0;
        end else begin
          parse_phase_next = sbl_pkg::PH_DONE1;
        end
      end

      unique case (parse_phase_next)
        sbl_pkg::PH_FIXED: begin
          if (field_left_next >= 33'(sbl_pkg::REC_LEN_AT) &&
              field_left_next < 33'(sbl_pkg::REC_FIXED_BYTES)) begin
            length_shift_next = length_shift_next |
                                (64'(in_q.body_byte) << {fixed_lane, 3'b000});
          end
          field_left_next = field_left_next + 33'd1;
          if (field_left_next >= 33'(sbl_pkg::REC_FIXED_BYTES)) begin
            field_left_next   = {1'b0, length_shift_next[31:0]} + 33'(sbl_pkg::REC_TAIL_BYTES);
            length_shift_next = '0;
            parse_phase_next  = sbl_pkg::PH_TAIL;
          end
        end
        sbl_pkg::PH_TAIL: begin
          field_left_next = field_left_next - 33'd1;
          if (field_left_next == '0) begin
            records_done_next = rd_inc;
            tail_wrap         = 1'b1;
            parse_phase_next  = sbl_pkg::PH_FIXED;
          end
        end
        sbl_pkg::PH_LEN1, sbl_pkg::PH_LEN2: begin
          length_shift_next = length_shift_next |
                              (64'(in_q.body_byte) << {field_left_next[1:0], 3'b000});
          field_left_next = field_left_next + 33'd1;
          if (field_left_next >= 33'd4) begin
            word_value        = length_shift_next;
            length_shift_next = '0;
            field_left_next   = '0;
            if (parse_phase_next == sbl_pkg::PH_LEN1) begin
              if (format_version == sbl_pkg::VER_2 && word_value == '0) begin
                first_error_next = sbl_pkg::ST_EMPTY_V2_SECTION;
              end else begin
                section_left_next = word_value;
                parse_phase_next  = sbl_pkg::PH_SEC1;
                if (word_value == '0) begin
                  if (format_version == sbl_pkg::VER_3) begin
                    parse_phase_next = sbl_pkg::PH_LEN2;
                  end else begin
                    parse_phase_next = sbl_pkg::PH_DONE2;
                  end
                end
              end
            end else begin
              section_left_next = word_value;
              parse_phase_next  = sbl_pkg::PH_SEC2;
              if (word_value == '0) begin
                parse_phase_next = sbl_pkg::PH_CNT;
              end
            end
          end
        end
        sbl_pkg::PH_SEC1: begin
          section_left_next = section_left_next - 64'd1;
          if (section_left_next == '0) begin
            if (format_version == sbl_pkg::VER_3) begin
              parse_phase_next  = sbl_pkg::PH_LEN2;
              field_left_next   = '0;
              length_shift_next = '0;
            end else begin
              parse_phase_next = sbl_pkg::PH_DONE2;
            end
          end
        end
        sbl_pkg::PH_SEC2: begin
          section_left_next = section_left_next - 64'd1;
          if (section_left_next == '0) begin
            parse_phase_next  = sbl_pkg::PH_CNT;
            field_left_next   = '0;
            length_shift_next = '0;
          end
        end
        sbl_pkg::PH_CNT: begin
          length_shift_next = length_shift_next |
                              (64'(in_q.body_byte) << {field_left_next[2:0], 3'b000});
          field_left_next = field_left_next + 33'd1;
          if (field_left_next >= 33'd8) begin
            word_value        = length_shift_next;
            length_shift_next = '0;
            field_left_next   = '0;
            if (word_value > sbl_pkg::COUNT_MAX) begin
              first_error_next = sbl_pkg::ST_COUNT_OVERFLOW;
            end else begin
              section_left_next = 64'(word_value * 64'(sbl_pkg::ENTRY_BYTES));
              parse_phase_next  = (section_left_next != '0) ? sbl_pkg::PH_ENTRIES :
                                                              sbl_pkg::PH_DONE3;
            end
          end
        end
        sbl_pkg::PH_ENTRIES: begin
          section_left_next = section_left_next - 64'd1;
          if (section_left_next == '0) begin
            parse_phase_next = sbl_pkg::PH_DONE3;
          end
        end
        sbl_pkg::PH_DONE1: first_error_next = sbl_pkg::ST_V1_TRAILING;
        sbl_pkg::PH_DONE2: first_error_next = sbl_pkg::ST_V2_TRAILING;
        default:           first_error_next = sbl_pkg::ST_V3_TRAILING;
      endcase
    end

    ge_end        = tail_wrap ? ge_inc : ge_now;
    settled_phase = parse_phase_next;
    if (parse_phase_next == sbl_pkg::PH_FIXED && field_left_next == '0 && ge_end) begin
      settled_phase = ver23 ? sbl_pkg::PH_LEN1 : sbl_pkg::PH_DONE1;
    end

    if (first_error_next != sbl_pkg::ST_RUNNING) begin
      end_status = first_error_next;
    end else begin
      unique case (settled_phase)
        sbl_pkg::PH_FIXED:   end_status = sbl_pkg::ST_TRUNC_RECORD;
        sbl_pkg::PH_TAIL:    end_status = sbl_pkg::ST_TRUNC_SCRIPT;
        sbl_pkg::PH_LEN1:    end_status = sbl_pkg::ST_MISSING_LEN1;
        sbl_pkg::PH_SEC1:    end_status = sbl_pkg::ST_TRUNC_SEC1;
        sbl_pkg::PH_LEN2:    end_status = sbl_pkg::ST_MISSING_LEN2;
        sbl_pkg::PH_SEC2:    end_status = sbl_pkg::ST_TRUNC_SEC2;
        sbl_pkg::PH_CNT:     end_status = sbl_pkg::ST_MISSING_COUNT;
        sbl_pkg::PH_ENTRIES: end_status = sbl_pkg::ST_TRUNC_ENTRIES;
        default:             end_status = sbl_pkg::ST_ACCEPTED;
      endcase
    end

    result.check_status = in_q.body_end ? end_status : first_error_next;
    result.records_seen = records_done_next;
    result.body_done    = in_q.body_end;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_q.body_end)) begin
      parse_phase  <= sbl_pkg::PH_FIXED;
      field_left   <= '0;
      records_done <= '0;
      length_shift <= '0;
      section_left <= '0;
      first_error  <= sbl_pkg::ST_RUNNING;
    end else if (advance) begin
      parse_phase  <= parse_phase_next;
      field_left   <= field_left_next;
      records_done <= records_done_next;
      length_shift <= length_shift_next;
      section_left <= section_left_next;
      first_error  <= first_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && in_q.body_end) |=>
      (parse_phase == sbl_pkg::PH_FIXED && records_done == '0 &&
       first_error == sbl_pkg::ST_RUNNING))
    else $error("parse state not cleared after final beat");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != sbl_pkg::ST_RUNNING && !(advance && in_q.body_end)) |=>
      (first_error == $past(first_error)))
    else $error("sticky error changed within a body");

  a_records_step: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_q.body_end) |=>
      (records_done == $past(records_done) || records_done == $past(records_done) + 40'd1))
    else $error("record count jumped");

  a_fixed_bound: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == sbl_pkg::PH_FIXED) |-> (field_left < 33'(sbl_pkg::REC_FIXED_BYTES)))
    else $error("fixed part index out of range");
`endif

endmodule
